### hw/rtl/u8fnv_pkg.sv
// Shared types, constants and helpers for the UTF-8 code point FNV-1a hasher.
// No dependencies; imported by every module of the block.
package u8fnv_pkg;

	localparam int HASH_W = 64;
	localparam int CP_W   = 21;
	localparam int BYTE_W = 8;

	// FNV-1a 64-bit offset basis and prime
	localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF29CE484222325;
	localparam logic [HASH_W-1:0] FNV_PRIME = 64'h00000100000001B3;

	// Command queue between decoder and hash unit
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Allowed range of the next continuation byte
	localparam logic [2:0] RULE_ANY = 3'd0; // 80..BF
	localparam logic [2:0] RULE_E0  = 3'd1; // A0..BF
	localparam logic [2:0] RULE_ED  = 3'd2; // 80..9F
	localparam logic [2:0] RULE_F0  = 3'd3; // 90..BF
	localparam logic [2:0] RULE_F4  = 3'd4; // 80..8F

	// One word from the decoder to the hash unit
	typedef struct packed {
		logic            mix;  // fold cp into the hash
		logic [CP_W-1:0] cp;
		logic            last; // end of string: emit result afterwards
		logic            err;  // sticky error for this string
	} cmd_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// Multiply by the FNV prime mod 2^64: prime = 2^40 + 0x1B3
	function automatic logic [HASH_W-1:0] mul_prime(input logic [HASH_W-1:0] x);
		mul_prime = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
			+ (x << 1) + x;
	endfunction

endpackage

### hw/rtl/u8fnv_in_if.sv
// Input channel: one UTF-8 byte word with valid/ready handshake.
// Depends on u8fnv_pkg for field widths.
interface u8fnv_in_if
	import u8fnv_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              byte_present;
	logic              end_of_string;

	modport source (output valid, data_byte, byte_present, end_of_string, input ready);
	modport sink   (input valid, data_byte, byte_present, end_of_string, output ready);
endinterface

### hw/rtl/u8fnv_out_if.sv
// Output channel: one hash result word with valid/ready handshake.
// Depends on u8fnv_pkg for field widths.
interface u8fnv_out_if
	import u8fnv_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [HASH_W-1:0] hash_value;
	logic              bad_encoding;

	modport source (output valid, hash_value, bad_encoding, input ready);
	modport sink   (input valid, hash_value, bad_encoding, output ready);
endinterface

### hw/rtl/u8fnv_front.sv
// Front end: strict UTF-8 decoder that turns bytes into hash commands.
// Depends on u8fnv_pkg and u8fnv_in_if.
module u8fnv_front
	import u8fnv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	u8fnv_in_if.sink    byte_in,
	input  qstat_t      qstat,
	output logic        push,
	output cmd_t        cmd
);

	logic [CP_W-1:0] part_q, part_n, part_c;
	logic [1:0]      rem_q, rem_n;
	logic [2:0]      rule_q, rule_n;
	logic            err_q, err_n;
	logic            accept, present, cont_ok, do_cont, cont_bad, do_lead;
	logic [BYTE_W-1:0] b;

	assign byte_in.ready = !qstat.full;
	assign accept        = byte_in.valid && byte_in.ready;
	assign b             = byte_in.data_byte;
	assign present       = byte_in.byte_present;

	// continuation range check per rule
	always_comb begin
		case (rule_q)
			RULE_E0: cont_ok = (b >= 8'hA0) && (b <= 8'hBF);
			RULE_ED: cont_ok = (b >= 8'h80) && (b <= 8'h9F);
			RULE_F0: cont_ok = (b >= 8'h90) && (b <= 8'hBF);
			RULE_F4: cont_ok = (b >= 8'h80) && (b <= 8'h8F);
			default: cont_ok = (b >= 8'h80) && (b <= 8'hBF);
		endcase
	end

	assign do_cont  = present && (rem_q != 2'd0) && cont_ok;
	assign cont_bad = present && (rem_q != 2'd0) && !cont_ok;
	assign do_lead  = present && !do_cont;
	assign part_c   = {part_q[CP_W-7:0], b[5:0]};

	// next decoder state and command word
	always_comb begin
		part_n  = part_q;
		rem_n   = rem_q;
		rule_n  = rule_q;
		err_n   = err_q;
		cmd.mix = 1'b0;
		cmd.cp  = '0;
		if (do_cont) begin
			rem_n  = rem_q - 2'd1;
			rule_n = RULE_ANY;
			if (rem_n == 2'd0) begin
				cmd.mix = 1'b1;
				cmd.cp  = part_c;
				part_n  = '0;
			end else begin
				part_n = part_c;
			end
		end
		// bad continuation: drop the sequence, reuse the byte as a lead
		if (cont_bad) begin
			err_n  = 1'b1;
			part_n = '0;
			rem_n  = 2'd0;
			rule_n = RULE_ANY;
		end
		if (do_lead) begin
			if (b < 8'h80) begin
				cmd.mix = 1'b1;
				cmd.cp  = {{(CP_W-BYTE_W){1'b0}}, b};
			end else if ((b >= 8'hC2) && (b <= 8'hDF)) begin
				part_n = {{(CP_W-5){1'b0}}, b[4:0]};
				rem_n  = 2'd1;
				rule_n = RULE_ANY;
			end else if ((b >= 8'hE0) && (b <= 8'hEF)) begin
				part_n = {{(CP_W-4){1'b0}}, b[3:0]};
				rem_n  = 2'd2;
				rule_n = (b == 8'hE0) ? RULE_E0 : (b == 8'hED) ? RULE_ED : RULE_ANY;
			end else if ((b >= 8'hF0) && (b <= 8'hF4)) begin
				part_n = {{(CP_W-3){1'b0}}, b[2:0]};
				rem_n  = 2'd3;
				rule_n = (b == 8'hF0) ? RULE_F0 : (b == 8'hF4) ? RULE_F4 : RULE_ANY;
			end else begin
				err_n = 1'b1;
			end
		end
		cmd.last = byte_in.end_of_string;
		// an open sequence at the end counts as truncated
		cmd.err  = err_n || (rem_n != 2'd0);
	end

	assign push = accept && (cmd.mix || cmd.last);

	// decoder state; cleared after every end of string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= '0;
			rem_q  <= 2'd0;
			rule_q <= RULE_ANY;
			err_q  <= 1'b0;
		end else if (accept) begin
			if (byte_in.end_of_string) begin
				part_q <= '0;
				rem_q  <= 2'd0;
				rule_q <= RULE_ANY;
				err_q  <= 1'b0;
			end else begin
				part_q <= part_n;
				rem_q  <= rem_n;
				rule_q <= rule_n;
				err_q  <= err_n;
			end
		end
	end

endmodule

### hw/rtl/u8fnv_queue.sv
// Small command FIFO between the decoder and the hash unit.
// Depends on u8fnv_pkg.
module u8fnv_queue
	import u8fnv_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  cmd_t   push_cmd,
	input  logic   pop,
	output cmd_t   head,
	output qstat_t qstat
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign qstat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign head        = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

### hw/rtl/u8fnv_back.sv
// Back end: FNV-1a state update and registered result output.
// Depends on u8fnv_pkg and u8fnv_out_if.
module u8fnv_back
	import u8fnv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        head,
	input  qstat_t      qstat,
	output logic        pop,
	u8fnv_out_if.source hash_out
);

	logic [HASH_W-1:0] hash_q, mixed;
	logic [HASH_W-1:0] res_hash_q;
	logic              res_err_q, res_valid_q;
	logic              out_free;

	assign out_free = !res_valid_q || hash_out.ready;
	// an end word needs room in the output register
	assign pop      = !qstat.empty && (!head.last || out_free);

	// xor-then-multiply step
	assign mixed = head.mix ? mul_prime(hash_q ^ {{(HASH_W-CP_W){1'b0}}, head.cp}) : hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q      <= FNV_BASIS;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				hash_q <= head.last ? FNV_BASIS : mixed;
			end
			if (pop && head.last) begin
				res_valid_q <= 1'b1;
			end else if (hash_out.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			res_hash_q <= mixed;
			res_err_q  <= head.err;
		end
	end

	assign hash_out.valid        = res_valid_q;
	assign hash_out.hash_value   = res_hash_q;
	assign hash_out.bad_encoding = res_err_q;

endmodule

### hw/rtl/utf8_codepoint_fnv1a_hash.sv
// UTF-8 code point FNV-1a 64-bit hasher, one byte word per cycle. A strict
// decoder in front turns bytes into code points and end markers, a 4-entry
// command queue decouples it from the hash unit, which folds each code point
// into the registered state with an xor and a shift-add multiply by the FNV
// prime. Input bytes are taken every cycle while the queue has room; the
// result of a string passes from its end word through the command queue into
// an output register, where it is held, so input continues while it waits
// until the queue fills. Malformed, overlong, surrogate, out-of-range and
// truncated sequences set bad_encoding; an empty string gives the offset basis.
// Depends on u8fnv_pkg, u8fnv_in_if, u8fnv_out_if and the u8fnv_* modules.
module utf8_codepoint_fnv1a_hash
	import u8fnv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	u8fnv_in_if.sink    byte_in,
	u8fnv_out_if.source hash_out
);

	cmd_t   push_cmd, head;
	qstat_t qstat;
	logic   push, pop;

	u8fnv_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_in),
		.qstat   (qstat),
		.push    (push),
		.cmd     (push_cmd)
	);

	u8fnv_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	u8fnv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.qstat    (qstat),
		.pop      (pop),
		.hash_out (hash_out)
	);

	// no write into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full))
		else $error("command queue overflow");

	// no read from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qstat.empty))
		else $error("command queue underflow");

	// an end word never overwrites a result still waiting
	a_no_result_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.last) |-> (!hash_out.valid || hash_out.ready))
		else $error("pending result overwritten");

endmodule

### dv/utf8_codepoint_fnv1a_hash_chk.sv
// Scoreboard for the UTF-8 code point FNV-1a hasher: it watches both channels,
// decodes accepted bytes into code points, predicts each hash and checks it.
// Depends on u8fnv_pkg, u8fnv_in_if and u8fnv_out_if.
module utf8_codepoint_fnv1a_hash_chk
	import u8fnv_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	u8fnv_in_if   byte_in,
	u8fnv_out_if  hash_out,
	output int    fail_count,
	output int    pending
);

	localparam logic [63:0] OFFSET_BASIS = 64'd14695981039346656037;
	localparam logic [63:0] HASH_PRIME   = 64'd1099511628211;
	localparam int          PRINT_CAP    = 100;

	typedef struct packed {
		logic [63:0] hash;
		logic        bad;
	} digest_t;

	// predicted decoder and hash state
	logic [63:0] hash_acc;
	logic [20:0] cp_acc;
	logic [1:0]  cont_left;
	logic [2:0]  next_rule;
	logic        err_flag;

	digest_t digest_q[$];
	digest_t due;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		fail_count++;
		if (fail_count <= PRINT_CAP)
			$display("%0t: %s: got %h, want %h", $time, what, got, want);
	endtask

	function automatic logic cont_in_range(input logic [7:0] b, input logic [2:0] rule);
		case (rule)
			RULE_E0: return b >= 8'hA0 && b <= 8'hBF;
			RULE_ED: return b >= 8'h80 && b <= 8'h9F;
			RULE_F0: return b >= 8'h90 && b <= 8'hBF;
			RULE_F4: return b >= 8'h80 && b <= 8'h8F;
			default: return b >= 8'h80 && b <= 8'hBF;
		endcase
	endfunction

	task automatic fold_cp(input logic [20:0] cp);
		hash_acc = (hash_acc ^ {43'd0, cp}) * HASH_PRIME;
	endtask

	task automatic clear_decoder();
		cp_acc    = '0;
		cont_left = '0;
		next_rule = RULE_ANY;
	endtask

	// lead byte: ASCII folds at once, multi-byte leads open a sequence
	task automatic start_lead(input logic [7:0] b);
		if (b < 8'h80) begin
			fold_cp({13'd0, b});
		end else if (b >= 8'hC2 && b <= 8'hDF) begin
			cp_acc    = {16'd0, b[4:0]};
			cont_left = 2'd1;
			next_rule = RULE_ANY;
		end else if (b >= 8'hE0 && b <= 8'hEF) begin
			cp_acc    = {17'd0, b[3:0]};
			cont_left = 2'd2;
			next_rule = (b == 8'hE0) ? RULE_E0 : (b == 8'hED) ? RULE_ED : RULE_ANY;
		end else if (b >= 8'hF0 && b <= 8'hF4) begin
			cp_acc    = {18'd0, b[2:0]};
			cont_left = 2'd3;
			next_rule = (b == 8'hF0) ? RULE_F0 : (b == 8'hF4) ? RULE_F4 : RULE_ANY;
		end else begin
			err_flag = 1'b1;
		end
	endtask

	// a bad continuation drops the sequence and is retried as a lead
	task automatic decode_byte(input logic [7:0] b);
		if (cont_left != 0 && cont_in_range(b, next_rule)) begin
			cp_acc    = {cp_acc[14:0], b[5:0]};
			cont_left = cont_left - 2'd1;
			next_rule = RULE_ANY;
			if (cont_left == 0) begin
				fold_cp(cp_acc);
				cp_acc = '0;
			end
		end else begin
			if (cont_left != 0) begin
				err_flag = 1'b1;
				clear_decoder();
			end
			start_lead(b);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_acc   = OFFSET_BASIS;
			err_flag   = 1'b0;
			clear_decoder();
			digest_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			// result words against the oldest prediction
			if (hash_out.valid && hash_out.ready) begin
				if (digest_q.size() == 0) begin
					report("hash word with nothing expected", hash_out.hash_value, '0);
				end else begin
					due = digest_q.pop_front();
					if (hash_out.hash_value !== due.hash)
						report("hash_value", hash_out.hash_value, due.hash);
					if (hash_out.bad_encoding !== due.bad)
						report("bad_encoding", {63'd0, hash_out.bad_encoding}, {63'd0, due.bad});
				end
			end
			// byte words feed the predictor; an end word closes the string
			if (byte_in.valid && byte_in.ready) begin
				if (byte_in.byte_present)
					decode_byte(byte_in.data_byte);
				if (byte_in.end_of_string) begin
					if (cont_left != 0)
						err_flag = 1'b1;
					digest_q.push_back('{hash: hash_acc, bad: err_flag});
					hash_acc = OFFSET_BASIS;
					err_flag = 1'b0;
					clear_decoder();
				end
			end
			pending = digest_q.size();
		end
	end

endmodule

### dv/utf8_codepoint_fnv1a_hash_tb.sv
// Top of the UTF-8 code point FNV-1a hasher bench: clock, reset, byte
// stimulus, output backpressure, stall watchdog and verdict.
// Depends on u8fnv_pkg, both channel interfaces, the block and its scoreboard.
module utf8_codepoint_fnv1a_hash_tb
	import u8fnv_pkg::*;
;

	localparam int ITEM_TARGET  = 1650;
	localparam int PAUSE_AT     = 800;
	localparam int QUIET_FROM   = 1000;
	localparam int QUIET_TO     = 1300;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 20;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	u8fnv_in_if  byte_in();
	u8fnv_out_if hash_out();

	int   fail_count;
	int   pending;
	int   words_sent;
	int   stall_cycles;
	bit   quiet;
	bit   paused_once;
	logic [7:0] str_buf[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	utf8_codepoint_fnv1a_hash u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_in),
		.hash_out (hash_out)
	);

	utf8_codepoint_fnv1a_hash_chk u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_in),
		.hash_out   (hash_out),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// receiver backpressure, off during the quiet stretch
	always @(negedge clk)
		hash_out.ready <= quiet || ($urandom_range(99) >= 20);

	// watchdog: too many cycles without any word moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_in.valid && byte_in.ready) || (hash_out.valid && hash_out.ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("utf8_codepoint_fnv1a_hash_tb: errors");
					$finish;
				end
			end
		end
	end

	// drive one word at the falling edge and hold it until taken
	task automatic send_word(input logic [7:0] b, input logic present, input logic eos);
		byte_in.valid         = 1'b1;
		byte_in.data_byte     = b;
		byte_in.byte_present  = present;
		byte_in.end_of_string = eos;
		@(posedge clk);
		while (!byte_in.ready)
			@(posedge clk);
		@(negedge clk);
		if (present || eos)
			words_sent++;
		if (!quiet && $urandom_range(99) < 20) begin
			byte_in.valid = 1'b0;
			repeat ($urandom_range(2, 1)) @(negedge clk);
		end
	endtask

	// send the buffered string; end on the last byte or as a separate word
	task automatic send_str(input bit sep_end);
		int i;
		for (i = 0; i < str_buf.size(); i++) begin
			if ($urandom_range(99) < 4)
				send_word(8'($urandom_range(255)), 1'b0, 1'b0);
			send_word(str_buf[i], 1'b1, !sep_end && i == str_buf.size() - 1);
		end
		if (sep_end || str_buf.size() == 0)
			send_word(8'($urandom_range(255)), 1'b0, 1'b1);
		str_buf.delete();
	endtask

	task automatic push_byte(input logic [7:0] b);
		str_buf.push_back(b);
	endtask

	// UTF-8 encoding of a scalar value
	task automatic push_cp(input logic [20:0] cp);
		if (cp < 21'h80) begin
			push_byte(cp[7:0]);
		end else if (cp < 21'h800) begin
			push_byte({3'b110, cp[10:6]});
			push_byte({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			push_byte({4'b1110, cp[15:12]});
			push_byte({2'b10, cp[11:6]});
			push_byte({2'b10, cp[5:0]});
		end else begin
			push_byte({5'b11110, cp[20:18]});
			push_byte({2'b10, cp[17:12]});
			push_byte({2'b10, cp[11:6]});
			push_byte({2'b10, cp[5:0]});
		end
	endtask

	// well-formed code point, biased toward the ends of each length class
	task automatic push_valid_cp();
		int unsigned lo;
		int unsigned hi;
		int unsigned cp;
		case ($urandom_range(3))
			0: begin lo = 'h0;     hi = 'h7F;     end
			1: begin lo = 'h80;    hi = 'h7FF;    end
			2: begin lo = 'h800;   hi = 'hFFFF;   end
			default: begin lo = 'h10000; hi = 'h10FFFF; end
		endcase
		if ($urandom_range(3) == 0)
			cp = $urandom_range(1) ? hi : lo;
		else
			cp = $urandom_range(hi, lo);
		if (cp >= 'hD800 && cp <= 'hDFFF)
			cp = $urandom_range(1) ? 'hD7FF : 'hE000;
		push_cp(cp[20:0]);
	endtask

	// malformed sequences: overlong, surrogate, above range, bad lead, cut short
	task automatic push_bad_seq();
		int need;
		int k;
		logic [7:0] lead;
		case ($urandom_range(7))
			0: begin
				push_byte(8'($urandom_range(8'hC1, 8'hC0)));
				push_byte(8'($urandom_range(8'hBF, 8'h80)));
			end
			1: begin
				push_byte(8'hE0);
				push_byte(8'($urandom_range(8'h9F, 8'h80)));
				push_byte(8'($urandom_range(8'hBF, 8'h80)));
			end
			2: begin
				push_byte(8'hED);
				push_byte(8'($urandom_range(8'hBF, 8'hA0)));
				push_byte(8'($urandom_range(8'hBF, 8'h80)));
			end
			3: begin
				push_byte(8'hF0);
				push_byte(8'($urandom_range(8'h8F, 8'h80)));
				push_byte(8'($urandom_range(8'hBF, 8'h80)));
				push_byte(8'($urandom_range(8'hBF, 8'h80)));
			end
			4: begin
				push_byte(8'hF4);
				push_byte(8'($urandom_range(8'hBF, 8'h90)));
				push_byte(8'($urandom_range(8'hBF, 8'h80)));
				push_byte(8'($urandom_range(8'hBF, 8'h80)));
			end
			5: push_byte(8'($urandom_range(8'hFF, 8'hF5)));
			6: push_byte(8'($urandom_range(8'hBF, 8'h80)));
			default: begin
				lead = 8'($urandom_range(8'hF4, 8'hC2));
				need = (lead >= 8'hF0) ? 3 : (lead >= 8'hE0) ? 2 : 1;
				push_byte(lead);
				for (k = $urandom_range(need - 1); k > 0; k--)
					push_byte(8'($urandom_range(8'hBF, 8'h80)));
			end
		endcase
	endtask

	task automatic random_string();
		int units;
		int r;
		units = $urandom_range(10);
		repeat (units) begin
			r = $urandom_range(99);
			if (r < 65)
				push_valid_cp();
			else if (r < 85)
				push_bad_seq();
			else
				push_byte(8'($urandom_range(255)));
		end
		send_str($urandom_range(99) < 30);
	endtask

	initial begin
		byte_in.valid         = 1'b0;
		byte_in.data_byte     = '0;
		byte_in.byte_present  = 1'b0;
		byte_in.end_of_string = 1'b0;
		words_sent            = 0;
		stall_cycles          = 0;
		quiet                 = 1'b0;
		paused_once           = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty string: end-only word
		send_word(8'h00, 1'b0, 1'b1);
		// one- and two-byte extremes, end carried by the last byte
		str_buf = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF};
		send_str(1'b0);
		// narrow second-byte ranges at their limits, an idle word, then end-only
		str_buf = '{8'hE0, 8'hA0, 8'h80, 8'hEF, 8'hBF, 8'hBF,
			8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_str(1'b0);
		send_word(8'hFF, 1'b0, 1'b0);
		send_word(8'h00, 1'b0, 1'b1);
		// bad lead, bad continuation retried as ASCII, sequence cut by the end
		str_buf = '{8'h80, 8'hC3, 8'h41, 8'hE2, 8'h82};
		send_str(1'b0);

		while (words_sent < ITEM_TARGET) begin
			// one hold-off until every hash has come back
			if (!paused_once && words_sent >= PAUSE_AT) begin
				byte_in.valid = 1'b0;
				while (pending != 0)
					@(negedge clk);
				paused_once = 1'b1;
			end
			quiet = words_sent >= QUIET_FROM && words_sent < QUIET_TO;
			random_string();
		end
		byte_in.valid = 1'b0;
		quiet         = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("utf8_codepoint_fnv1a_hash_tb: clean");
		else
			$display("utf8_codepoint_fnv1a_hash_tb: errors");
		$finish;
	end

endmodule
